>>> sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

>>> sv/tcgr_pkg.sv
`default_nettype none
package tcgr_pkg;

   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_COUNT  = 256;
   localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int ROW_W        = $clog2(GLYPH_HEIGHT);

   localparam int COL_W    = 8;
   localparam int LINE_W   = 7;
   localparam int PITCH_W  = 13;
   localparam int COLOUR_W = 32;
   localparam int ADDR_W   = 23;
   localparam int SCAN_W   = LINE_W + ROW_W;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] MODE_CHAR   = 2'd0;
   localparam logic [1:0] MODE_CURSOR = 2'd1;
   localparam logic [1:0] MODE_GLYPH  = 2'd2;

   localparam logic [7:0] CHR_TAB      = 8'h09;
   localparam logic [7:0] CHR_LF       = 8'h0A;
   localparam logic [7:0] CHR_CR       = 8'h0D;
   localparam logic [7:0] CHR_PRINT_LO = 8'h20;
   localparam logic [7:0] CHR_PRINT_HI = 8'hDB;
   localparam int         TAB_STOP     = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FG_COLOUR    = 3'd0,
      REG_BG_COLOUR    = 3'd1,
      REG_LINE_PITCH   = 3'd2,
      REG_TEXT_COLUMNS = 3'd3,
      REG_TEXT_ROWS    = 3'd4
   } csr_index_type;

   // sequencer commands to the address unit
   typedef struct packed {
      logic load_mul;
      logic load_base;
      logic step;
   } addr_ctrl_type;

   function automatic logic [STORE_AW-1:0] glyph_index(input logic [7:0] code,
                                                       input logic [STORE_AW-1:0] row);
      glyph_index = STORE_AW'(code) * STORE_AW'(GLYPH_HEIGHT) + row;
   endfunction

endpackage
`default_nettype wire

>>> sv/tcgr_ram.sv
`default_nettype none
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> sv/tcgr_addr_unit.sv
`default_nettype none
module tcgr_addr_unit (
   input  wire logic                          clock,
   input  wire tcgr_pkg::addr_ctrl_type       ctrl,
   input  wire logic [tcgr_pkg::LINE_W-1:0]   cursor_line,
   input  wire logic [tcgr_pkg::COL_W-1:0]    cursor_column,
   input  wire logic [tcgr_pkg::PITCH_W-1:0]  line_pitch,
   output logic      [tcgr_pkg::ADDR_W-1:0]   pixel_address
);

   logic [tcgr_pkg::SCAN_W-1:0]                  scan;
   logic [tcgr_pkg::SCAN_W+tcgr_pkg::PITCH_W-1:0] product;
   logic [tcgr_pkg::ADDR_W-1:0]                  prod_ff;
   logic [tcgr_pkg::ADDR_W-1:0]                  addr_ff;
   logic [tcgr_pkg::ADDR_W-1:0]                  add_a;
   logic [tcgr_pkg::ADDR_W-1:0]                  add_b;
   logic [tcgr_pkg::ADDR_W-1:0]                  sum;

   assign scan    = tcgr_pkg::SCAN_W'(cursor_line) * tcgr_pkg::SCAN_W'(tcgr_pkg::GLYPH_HEIGHT);
   assign product = (tcgr_pkg::SCAN_W + tcgr_pkg::PITCH_W)'(scan)
                  * (tcgr_pkg::SCAN_W + tcgr_pkg::PITCH_W)'(line_pitch);

   // one adder: base = top scanline + column offset, then one pitch per row
   always_comb begin
      if (ctrl.load_base) begin
         add_a = prod_ff;
         add_b = tcgr_pkg::ADDR_W'(cursor_column) * tcgr_pkg::ADDR_W'(tcgr_pkg::GLYPH_WIDTH);
      end else begin
         add_a = addr_ff;
         add_b = tcgr_pkg::ADDR_W'(line_pitch);
      end
   end

   assign sum = add_a + add_b;

   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod_ff <= product[tcgr_pkg::ADDR_W-1:0];
      end
      if (ctrl.load_base || ctrl.step) begin
         addr_ff <= sum;
      end
   end

   assign pixel_address = addr_ff;

endmodule
`default_nettype wire

>>> sv/text_console_glyph_renderer_unit.sv
// Text console renderer with an 8-pixel-wide glyph RAM. A glyph-load or
// set-cursor transaction, and a control or ignored byte, complete in the
// cycle they are accepted. A printable byte (0x20..0xDB) is accepted,
// passes the scanline multiplier and then the shared address adder, then
// emits its glyph rows at one per cycle unless the output stalls, one RAM
// read and one pitch add each. The input is stalled while a glyph is
// prepared or emitted. The glyph RAM is not cleared after reset; load
// every glyph row before printing it. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
module text_console_glyph_renderer_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_mode,
   input  wire logic [7:0]                       req_char_code,
   input  wire logic [7:0]                       req_cursor_col,
   input  wire logic [6:0]                       req_cursor_row,
   input  wire logic [3:0]                       req_glyph_line,
   input  wire logic [7:0]                       req_glyph_bits,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [tcgr_pkg::ADDR_W-1:0]           rsp_pixel_address,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_0,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_1,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_2,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_3,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_4,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_5,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_6,
   output logic [tcgr_pkg::COLOUR_W-1:0]         rsp_pixel_7,
   output logic                                  rsp_last_row,
   input  wire logic                             csr_we,
   input  wire logic [tcgr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tcgr_pkg::COLOUR_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_BASE = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [tcgr_pkg::COLOUR_W-1:0] fg_ff, bg_ff;
   logic [tcgr_pkg::PITCH_W-1:0]  pitch_ff;
   logic [tcgr_pkg::COL_W-1:0]    cols_ff;
   logic [tcgr_pkg::LINE_W-1:0]   rows_ff;

   logic [tcgr_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcgr_pkg::LINE_W-1:0]   line_ff, line_in;
   logic [7:0]                    code_ff, code_in;
   logic [tcgr_pkg::ROW_W-1:0]    row_ff, row_in;

   logic                          accept;
   logic                          last;
   logic [tcgr_pkg::LINE_W:0]     line_next;
   logic [tcgr_pkg::COL_W:0]      col_next;
   logic [tcgr_pkg::COL_W:0]      tab_next;
   logic [tcgr_pkg::LINE_W-1:0]   line_adv;

   tcgr_pkg::addr_ctrl_type       actrl;
   logic                          ram_we;
   logic [tcgr_pkg::STORE_AW-1:0] ram_waddr;
   logic                          ram_re;
   logic [tcgr_pkg::STORE_AW-1:0] ram_raddr;
   logic [7:0]                    ram_q;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_EMIT);
   assign last      = (32'(row_ff) == 32'(tcgr_pkg::GLYPH_HEIGHT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff    <= 32'h00FF_FFFF;
         bg_ff    <= '0;
         pitch_ff <= 13'd1024;
         cols_ff  <= 8'd128;
         rows_ff  <= 7'd48;
      end else if (csr_we) begin
         case (csr_index)
            tcgr_pkg::REG_FG_COLOUR:    fg_ff    <= csr_wdata;
            tcgr_pkg::REG_BG_COLOUR:    bg_ff    <= csr_wdata;
            tcgr_pkg::REG_LINE_PITCH:   pitch_ff <= csr_wdata[tcgr_pkg::PITCH_W-1:0];
            tcgr_pkg::REG_TEXT_COLUMNS: cols_ff  <= csr_wdata[tcgr_pkg::COL_W-1:0];
            tcgr_pkg::REG_TEXT_ROWS:    rows_ff  <= csr_wdata[tcgr_pkg::LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // cursor candidates, limit tests are reaches-or-passes
   assign line_next = {1'b0, line_ff} + 1'b1;
   assign line_adv  = (line_next >= {1'b0, rows_ff}) ? '0 : line_next[tcgr_pkg::LINE_W-1:0];
   assign col_next  = {1'b0, col_ff} + 1'b1;
   assign tab_next  = ({1'b0, col_ff} & ~(tcgr_pkg::COL_W + 1)'(tcgr_pkg::TAB_STOP - 1))
                    + (tcgr_pkg::COL_W + 1)'(tcgr_pkg::TAB_STOP);

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      line_in   = line_ff;
      code_in   = code_ff;
      row_in    = row_ff;
      actrl     = '0;
      ram_we    = 1'b0;
      ram_waddr = tcgr_pkg::glyph_index(req_char_code, tcgr_pkg::STORE_AW'(req_glyph_line));
      ram_re    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  tcgr_pkg::MODE_GLYPH: begin
                     ram_we = (32'(req_glyph_line) < 32'(tcgr_pkg::GLYPH_HEIGHT));
                  end
                  tcgr_pkg::MODE_CURSOR: begin
                     col_in  = (req_cursor_col >= cols_ff) ? '0 : req_cursor_col;
                     line_in = (req_cursor_row >= rows_ff) ? '0 : req_cursor_row;
                  end
                  tcgr_pkg::MODE_CHAR: begin
                     if (req_char_code == tcgr_pkg::CHR_LF) begin
                        if (line_next >= {1'b0, rows_ff}) begin
                           line_in = '0;
                           col_in  = '0;
                        end else begin
                           line_in = line_next[tcgr_pkg::LINE_W-1:0];
                        end
                     end else if (req_char_code == tcgr_pkg::CHR_CR) begin
                        col_in = '0;
                     end else if (req_char_code == tcgr_pkg::CHR_TAB) begin
                        if (tab_next >= {1'b0, cols_ff}) begin
                           col_in  = '0;
                           line_in = line_adv;
                        end else begin
                           col_in = tab_next[tcgr_pkg::COL_W-1:0];
                        end
                     end else if (req_char_code inside
                                  {[tcgr_pkg::CHR_PRINT_LO:tcgr_pkg::CHR_PRINT_HI]}) begin
                        code_in  = req_char_code;
                        state_in = S_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            actrl.load_mul = 1'b1;
            state_in       = S_BASE;
         end
         S_BASE: begin
            actrl.load_base = 1'b1;
            ram_re          = 1'b1;
            row_in          = '0;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               if (last) begin
                  state_in = S_IDLE;
                  if (col_next >= {1'b0, cols_ff}) begin
                     col_in  = '0;
                     line_in = line_adv;
                  end else begin
                     col_in = col_next[tcgr_pkg::COL_W-1:0];
                  end
               end else begin
                  actrl.step = 1'b1;
                  ram_re     = 1'b1;
                  row_in     = row_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign ram_raddr = tcgr_pkg::glyph_index(code_ff, tcgr_pkg::STORE_AW'(row_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
         line_ff  <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         line_ff  <= line_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   tcgr_ram #(
      .WIDTH (8),
      .DEPTH (tcgr_pkg::STORE_DEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_glyph_bits),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   tcgr_addr_unit u_addr (
      .clock         (clock),
      .ctrl          (actrl),
      .cursor_line   (line_ff),
      .cursor_column (col_ff),
      .line_pitch    (pitch_ff),
      .pixel_address (rsp_pixel_address)
   );

   // msb of the glyph row is the leftmost pixel
   assign rsp_pixel_0  = ram_q[7] ? fg_ff : bg_ff;
   assign rsp_pixel_1  = ram_q[6] ? fg_ff : bg_ff;
   assign rsp_pixel_2  = ram_q[5] ? fg_ff : bg_ff;
   assign rsp_pixel_3  = ram_q[4] ? fg_ff : bg_ff;
   assign rsp_pixel_4  = ram_q[3] ? fg_ff : bg_ff;
   assign rsp_pixel_5  = ram_q[2] ? fg_ff : bg_ff;
   assign rsp_pixel_6  = ram_q[1] ? fg_ff : bg_ff;
   assign rsp_pixel_7  = ram_q[0] ? fg_ff : bg_ff;
   assign rsp_last_row = last;

endmodule
`default_nettype wire

>>> sv/tcgr_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tcgr_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [tcgr_pkg::ADDR_W-1:0]      rsp_pixel_address,
   input wire logic                             rsp_last_row
);

   // no new transaction is taken while glyph rows are still going out
   `ASSERT_IMPLY(busy_while_emitting, clock, reset, rsp_valid, req_stall)

   // a stalled row keeps its address
   `ASSERT_NEXT(stalled_row_holds, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_pixel_address) && $stable(rsp_last_row))

   // rows of one glyph come back to back
   `ASSERT_NEXT(rows_back_to_back, clock, reset, rsp_valid && !rsp_stall && !rsp_last_row,
                rsp_valid && !rsp_last_row || rsp_valid && rsp_last_row)

   // the glyph ends after its final row
   `ASSERT_NEXT(glyph_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last_row,
                !rsp_valid && !req_stall)

endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);
`default_nettype wire
